// ===== hdl/u16u8_pkg.sv =====
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other file of the block imports this package.
package u16u8_pkg;

    // Surrogate ranges and fixed code points
    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;
    localparam logic [20:0] MAX_ONE_BYTE    = 21'h00007F;
    localparam logic [20:0] MAX_TWO_BYTE    = 21'h0007FF;
    localparam logic [20:0] MAX_THREE_BYTE  = 21'h00FFFF;
    localparam logic [7:0]  LEAD_TWO        = 8'hC0;
    localparam logic [7:0]  LEAD_THREE      = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR       = 8'hF0;
    localparam logic [7:0]  CONT_MARK       = 8'h80;

    // U+FFFD as UTF-8, first byte at index 0
    localparam logic [2:0][7:0] REPL_BYTES = {8'hBD, 8'hBF, 8'hEF};
    localparam logic [2:0]      REPL_LEN   = 3'd3;

    // Longest run of bytes one code unit can cause
    localparam int MAX_JOB_BYTES = 6;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One encoded code point: up to four bytes, first at index 0
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } u16u8_enc_t;

    // One unit's worth of output bytes, handed from front to back
    typedef struct packed {
        logic [MAX_JOB_BYTES-1:0][7:0] bytes;
        logic [MAX_JOB_BYTES-1:0]      repl_mask;
        logic [2:0]                    count;
    } u16u8_job_t;

    // Encode a code point of up to 21 bits as one to four UTF-8 bytes
    function automatic u16u8_enc_t encode_cp(input logic [20:0] cp);
        u16u8_enc_t e;
        e = '0;
        if (cp <= MAX_ONE_BYTE) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end
        else if (cp <= MAX_TWO_BYTE) begin
            e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd2;
        end
        else if (cp <= MAX_THREE_BYTE) begin
            e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd3;
        end
        else begin
            e.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

// ===== hdl/u16u8_front.sv =====
// Front end: accepts UTF-16 words, tracks a held high surrogate and builds byte jobs.
// Depends on u16u8_pkg.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    input  logic        q_full,
    output logic        q_push,
    output u16u8_job_t  q_job
);

    typedef enum logic [1:0] {
        SECOND_NONE,
        SECOND_PAIR,
        SECOND_REPL,
        SECOND_PLAIN
    } second_kind_t;

    logic        pending_reg, pending_next;
    logic [9:0]  held_reg, held_next;
    logic        is_high, is_low, accept, first_repl;
    second_kind_t second_kind;
    logic [20:0] pair_cp;
    u16u8_enc_t  enc2;
    logic [3:0][7:0] b2;
    logic [2:0]  n2;
    logic        r2;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the incoming word
    assign is_high = (code_unit >= HIGH_SURR_FIRST) && (code_unit <= HIGH_SURR_LAST);
    assign is_low  = (code_unit >= LOW_SURR_FIRST) && (code_unit <= LOW_SURR_LAST);
    assign pair_cp = SUPP_BASE + {1'b0, held_reg, code_unit[9:0]};

    // Decide what the word emits after any replacement for a held surrogate
    always_comb
    begin
        first_repl = pending_reg && !is_low;
        if (pending_reg && is_low) begin
            second_kind = SECOND_PAIR;
        end
        else if (is_high) begin
            second_kind = end_of_text ? SECOND_REPL : SECOND_NONE;
        end
        else if (is_low) begin
            second_kind = SECOND_REPL;
        end
        else begin
            second_kind = SECOND_PLAIN;
        end
    end

    // Encode the second part
    always_comb
    begin
        enc2 = encode_cp((second_kind == SECOND_PAIR) ? pair_cp : {5'b00000, code_unit});
        b2   = '0;
        n2   = 3'd0;
        r2   = 1'b0;
        unique case (second_kind)
            SECOND_NONE:
            begin
                n2 = 3'd0;
            end
            SECOND_REPL:
            begin
                b2[2:0] = REPL_BYTES;
                n2      = REPL_LEN;
                r2      = 1'b1;
            end
            SECOND_PAIR, SECOND_PLAIN:
            begin
                b2 = enc2.bytes;
                n2 = enc2.len;
            end
            default:
            begin
                n2 = 3'd0;
            end
        endcase
    end

    // Assemble the job: optional replacement first, then the second part
    always_comb
    begin
        q_job = '0;
        if (first_repl) begin
            for (int i = 0; i < 3; i++) begin
                q_job.bytes[i]     = REPL_BYTES[i];
                q_job.repl_mask[i] = 1'b1;
            end
            for (int i = 3; i < MAX_JOB_BYTES; i++) begin
                q_job.bytes[i]     = b2[i-3];
                q_job.repl_mask[i] = r2;
            end
            q_job.count = REPL_LEN + n2;
        end
        else begin
            for (int i = 0; i < 4; i++) begin
                q_job.bytes[i]     = b2[i];
                q_job.repl_mask[i] = r2;
            end
            q_job.count = n2;
        end
    end

    // Push only jobs that carry bytes
    assign q_push = accept && (q_job.count != 3'd0);

    // Hold or drop the high surrogate
    always_comb
    begin
        pending_next = pending_reg;
        held_next    = held_reg;
        if (accept) begin
            if (second_kind == SECOND_NONE) begin
                pending_next = 1'b1;
                held_next    = code_unit[9:0];
            end
            else begin
                pending_next = 1'b0;
                held_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= 1'b0;
            held_reg    <= '0;
        end
        else begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

endmodule

// ===== hdl/u16u8_queue.sv =====
// Short queue of byte jobs between the front and back ends.
// Depends on u16u8_pkg.
module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  u16u8_job_t push_job,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output u16u8_job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u16u8_job_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/u16u8_back.sv =====
// Back end: walks a byte job one byte per cycle into the output register while out_stall is low.
// Depends on u16u8_pkg.
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  u16u8_job_t head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       replaced
);

    u16u8_job_t job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       olast_reg, olast_next;
    logic       orepl_reg, orepl_next;
    logic       advance, emitting, is_last;

    // The output register moves when empty or taken
    assign advance  = !ovalid_reg || !out_stall;
    assign emitting = advance && busy_reg;
    assign is_last  = (idx_reg == job_reg.count - 3'd1);
    assign pop      = head_valid && (!busy_reg || (emitting && is_last));

    // Step through the current job, load the next one
    always_comb
    begin
        job_next    = job_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        orepl_next  = orepl_reg;
        if (advance) begin
            ovalid_next = busy_reg;
            obyte_next  = job_reg.bytes[idx_reg];
            olast_next  = is_last;
            orepl_next  = job_reg.repl_mask[idx_reg];
        end
        if (emitting) begin
            idx_next = idx_reg + 3'd1;
            if (is_last) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            job_next  = head_job;
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        orepl_reg <= orepl_next;
    end

    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign last_of_run = olast_reg;
    assign replaced    = orepl_reg;

endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder, top level.
// Input channel: in_valid / in_stall with code_unit and end_of_text, one UTF-16
//   word per accepted cycle. A word is taken whenever the job queue has room,
//   so words enter back to back while earlier bytes are still going out.
// Output channel: out_valid / out_stall with out_byte, last_of_run and replaced,
//   one UTF-8 byte per cycle unless stalled. last_of_run marks the final byte a word caused.
// A high surrogate with no end_of_text produces nothing until the next word;
//   bad surrogates come out as EF BF BD with replaced set.
// With the queue and back end idle, the first byte of a word passes through a queue
//   entry, the back end's job register and the output register before out_valid
//   rises. Throughput: one output byte per cycle while out_stall is low, set by
//   the byte sequencer in the back end.
// When the receiver stalls, the output byte holds; the queue fills and then
//   in_stall rises. Reset clears the held surrogate, the queue and the output.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        replaced
);

    u16u8_job_t push_job, head_job;
    logic       push, full, pop, head_valid;

    // Classify words and build jobs
    u16u8_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .q_full      (full),
        .q_push      (push),
        .q_job       (push_job)
    );

    // Decouple front and back
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Emit bytes
    u16u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .replaced    (replaced)
    );

endmodule
